>>> sv/fqvr_pkg.sv
// Package with shared codes, widths and control types of the value-removal FIFO.
`timescale 1ns / 1ps

package fqvr_pkg;

	// Default number of queue entries.
	localparam int FQVR_DEPTH = 16;

	// Field widths of one request and one result.
	localparam int ACT_W    = 2;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 5;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	// Action codes of a request.
	localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// Status codes of a result.
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load_in;   // latch the accepted request
		logic              walk_zero; // start a walk at entry zero
		logic              walk_shift; // start a walk behind the removed entry
		logic              walk;      // step the read walk
		logic              shift_wr;  // write the walked entry one slot lower
		logic              push;      // write the value at the tail
		logic              dec_cnt;   // one entry fewer
		logic              head_rd;   // read entry zero
		logic              head_cap;  // capture the read head value
		logic              load_out;  // load the result register
		logic [STAT_W-1:0] status;    // status for the result
	} fqvr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACT_W-1:0] act;        // action of the latched request
		logic             cnt_zero;   // queue is empty
		logic             full;       // queue holds every entry
		logic             hit;        // entry on the read port matches
		logic             miss_end;   // last entry read without a match
		logic             shift_done; // compaction finished this cycle
		logic             out_busy;   // result register still occupied
	} fqvr_stat_t;

endpackage

>>> sv/fqvr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fqvr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/fqvr_datapath.sv
// Datapath of the value-removal FIFO: entry memory, walk counters, head and result registers.
`timescale 1ns / 1ps

module fqvr_datapath
	import fqvr_pkg::*;
#(
	parameter int DEPTH = FQVR_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fqvr_cmd_t           cmd,
	output fqvr_stat_t          stat,
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [ACT_W-1:0]        act_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           ra_q;
	logic                    pv_q;
	logic [AW-1:0]           pidx_q;
	logic signed [VAL_W-1:0] head_q;

	logic                    out_valid_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic signed [VAL_W-1:0] out_head_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [VAL_W-1:0]        wr_data;
	logic [AW-1:0]           rd_addr;
	logic [VAL_W-1:0]        rd_data;
	logic [CW-1:0]           shift_start;
	logic                    ra_in_range;
	logic                    pidx_last;

	// Entry store.
	fqvr_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Walk bookkeeping: the first entry to move after a removal, and the last filled slot.
	assign shift_start = (act_q == ACT_POP) ? CW'(1) : (CW'(pidx_q) + CW'(1));
	assign ra_in_range = (ra_q < cnt_q);
	assign pidx_last   = ((CW'(pidx_q) + CW'(1)) == cnt_q);

	// Memory port selection.
	assign rd_addr = cmd.head_rd ? AW'(0) : ra_q[AW-1:0];
	assign wr_en   = cmd.push || (cmd.shift_wr && pv_q);
	assign wr_addr = cmd.push ? cnt_q[AW-1:0] : AW'(pidx_q - AW'(1));
	assign wr_data = cmd.push ? val_q : rd_data;

	// Request registers.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= s_tdata[ACT_W-1:0];
			val_q <= s_tdata[ACT_W+VAL_W-1:ACT_W];
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.dec_cnt) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Read walk: the read address leads, and the index of the data on the read port follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q   <= '0;
			pv_q   <= 1'b0;
			pidx_q <= '0;
		end else if (cmd.walk_zero) begin
			ra_q <= '0;
			pv_q <= 1'b0;
		end else if (cmd.walk_shift) begin
			ra_q <= shift_start;
			pv_q <= 1'b0;
		end else if (cmd.walk) begin
			pv_q   <= ra_in_range;
			pidx_q <= ra_q[AW-1:0];
			if (ra_in_range) begin
				ra_q <= ra_q + CW'(1);
			end
		end
	end

	// Head value kept for steps that do not move it.
	always_ff @(posedge clk) begin
		if (cmd.push && (cnt_q == '0)) begin
			head_q <= val_q;
		end else if (cmd.head_cap) begin
			head_q <= rd_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= cmd.status;
			out_count_q  <= COUNT_W'(cnt_q);
			out_head_q   <= (cnt_q == '0) ? '0 : head_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.act        = act_q;
		stat.cnt_zero   = (cnt_q == '0);
		stat.full       = (cnt_q == CW'(DEPTH));
		stat.hit        = pv_q && (rd_data == val_q);
		stat.miss_end   = pv_q && (rd_data != val_q) && pidx_last;
		stat.shift_done = (pv_q && pidx_last) || (!pv_q && !ra_in_range);
		stat.out_busy   = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_head_q, out_count_q, out_status_q};

endmodule

>>> sv/fqvr_ctrl.sv
// Controller state machine of the value-removal FIFO.
`timescale 1ns / 1ps

module fqvr_ctrl
	import fqvr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  fqvr_stat_t stat,
	output fqvr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_SEARCH   = 3'd2;
	localparam logic [2:0] S_SHIFT    = 3'd3;
	localparam logic [2:0] S_HEAD_RD  = 3'd4;
	localparam logic [2:0] S_HEAD_CAP = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d = ST_OK;
				state_d  = S_FINISH;
				unique case (stat.act)
					ACT_PUSH: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					ACT_POP: begin
						if (stat.cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							cmd.walk_shift = 1'b1;
							state_d        = S_SHIFT;
						end
					end
					ACT_REMOVE: begin
						if (stat.cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							cmd.walk_zero = 1'b1;
							state_d       = S_SEARCH;
						end
					end
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				priority if (stat.hit) begin
					cmd.walk_shift = 1'b1;
					state_d        = S_SHIFT;
				end else if (stat.miss_end) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_FINISH;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.walk     = 1'b1;
				cmd.shift_wr = 1'b1;
				if (stat.shift_done) begin
					cmd.dec_cnt = 1'b1;
					state_d     = S_HEAD_RD;
				end
			end
			S_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_HEAD_CAP;
			end
			S_HEAD_CAP: begin
				cmd.head_cap = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

>>> sv/fifo_queue_with_value_removal_top.sv
// Top level of the FIFO of signed values with append, head drop and removal by value.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | s_tdata: action, value
//  m_      | out | m_tvalid / m_tready | m_tdata: status, count, head_value
//
// One request is worked at a time. From acceptance to the result register load, an
// append, a full or empty error and the unused action go straight from decode to the
// result; a head drop runs the compaction walk through the entry RAM's single read port
// and then reads the new head. Removal by value searches from the head to a match, then
// moves only the entries behind it and reads the new head; a miss goes to the result.
// The block is ready for the next request in the cycle after the load. Reset empties
// the queue; the entry RAM is not cleared. The next request is taken while a result
// still waits on m_; a result that is not taken stalls the next one.
`timescale 1ns / 1ps

module fifo_queue_with_value_removal_top
	import fqvr_pkg::*;
#(
	parameter int DEPTH = FQVR_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [1:0] action, [33:2] value, [39:34] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // [1:0] status, [6:2] count, [38:7] head_value
);

	fqvr_cmd_t  cmd;
	fqvr_stat_t stat;

	// Controller.
	fqvr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath.
	fqvr_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

>>> sim/fqvr_result_checker.sv
// Checker that predicts and compares every result of the value-removal FIFO.
`timescale 1ns / 1ps

module fqvr_result_checker
	import fqvr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [1:0] action, [33:2] value, [39:34] zero
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,  // [1:0] status, [6:2] count, [38:7] head_value
	output int                  mismatch_count,
	output int                  outstanding
);

	// Only the first failures are printed so that a broken block cannot flood the log.
	localparam int REPORT_CAP = 60;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic [COUNT_W-1:0]       count;
		logic signed [VAL_W-1:0]  head_value;
	} queue_result_t;

	// Mirror of the queue contents; slot 0 is the head.
	logic signed [VAL_W-1:0] held_values [FQVR_DEPTH];
	int unsigned             held_count = 0;
	queue_result_t           expected_results [$];

	// Close the gap left by the entry at pos.
	function automatic void drop_entry(input int unsigned pos);
		for (int unsigned k = pos; k + 1 < held_count; k++) begin
			held_values[k] = held_values[k + 1];
		end
		held_count--;
	endfunction

	// Apply one request to the mirror and return the result the block must give.
	function automatic queue_result_t apply_queue_command(input logic [ACT_W-1:0] act,
			input logic signed [VAL_W-1:0] val);
		queue_result_t res;
		bit            found;
		res.status = ST_OK;
		found = 1'b0;
		case (act)
			ACT_PUSH: begin
				if (held_count >= FQVR_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					held_values[held_count] = val;
					held_count++;
				end
			end
			ACT_POP: begin
				if (held_count == 0) res.status = ST_EMPTY;
				else drop_entry(0);
			end
			ACT_REMOVE: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					// The entry nearest the head wins; the last entry is searched too.
					for (int unsigned k = 0; k < held_count && !found; k++) begin
						if (held_values[k] == val) begin
							drop_entry(k);
							found = 1'b1;
						end
					end
					if (!found) res.status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		res.count = held_count[COUNT_W-1:0];
		res.head_value = (held_count > 0) ? held_values[0] : '0;
		return res;
	endfunction

	// Count a wrong field and report it while under the cap.
	task automatic report_field(input string field, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	// Compare results first so that a request taken on the same edge cannot hide one.
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			held_count = 0;
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP) begin
						$error("result with no request waiting: %h", m_tdata);
					end
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[STAT_W-1:0] !== want.status) begin
						report_field("status", want.status, m_tdata[STAT_W-1:0]);
					end
					if (m_tdata[STAT_W+COUNT_W-1:STAT_W] !== want.count) begin
						report_field("count", want.count, m_tdata[STAT_W+COUNT_W-1:STAT_W]);
					end
					if (m_tdata[STAT_W+COUNT_W+VAL_W-1:STAT_W+COUNT_W] !== want.head_value) begin
						report_field("head_value", want.head_value,
							$signed(m_tdata[STAT_W+COUNT_W+VAL_W-1:STAT_W+COUNT_W]));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_queue_command(s_tdata[ACT_W-1:0],
					s_tdata[ACT_W+VAL_W-1:ACT_W]));
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> sim/tb.sv
// Testbench top for the value-removal FIFO: stimulus, reset, ready stalls and verdict.
`timescale 1ns / 1ps

module tb
	import fqvr_pkg::*;
;

	// The spare action code, which the block must ignore.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_ITEMS  = 150;
	localparam int PHASE_LEN    = 40;
	localparam int POOL_SIZE    = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	int                  mismatch_count;
	int                  outstanding;
	bit                  idling_on = 1'b1;
	int                  stall_left = 0;

	fifo_queue_with_value_removal_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fqvr_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #5 clk = ~clk;

	// Receiver stalls come in bursts, started at random while idling is on.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val);
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W - ACT_W - VAL_W){1'b0}}, val, act};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every predicted result has been taken.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Runaway guard.
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic signed [VAL_W-1:0] value_pool [POOL_SIZE];
		logic [ACT_W-1:0]        act;
		logic signed [VAL_W-1:0] val;
		int                      roll;
		bit                      filling;

		foreach (value_pool[k]) value_pool[k] = $urandom();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue on pop, removal and the spare action.
		send_request(ACT_POP, 0);
		send_request(ACT_REMOVE, 0);
		send_request(ACT_SPARE, 32'sh5555_5555);
		// Extremes, duplicates, a miss, a middle removal and removal of the sole entry.
		send_request(ACT_PUSH, 32'sh8000_0000);
		send_request(ACT_PUSH, 32'sh7FFF_FFFF);
		send_request(ACT_PUSH, 7);
		send_request(ACT_PUSH, 7);
		send_request(ACT_REMOVE, 7);
		send_request(ACT_REMOVE, 12345);
		send_request(ACT_REMOVE, 32'sh7FFF_FFFF);
		send_request(ACT_POP, 0);
		send_request(ACT_REMOVE, 7);
		// Fill to the top, append once more, then remove the tail entry by value.
		for (int k = 0; k < FQVR_DEPTH; k++) begin
			send_request(ACT_PUSH, (k == FQVR_DEPTH - 1) ? -2 : $urandom());
		end
		send_request(ACT_PUSH, -1);
		send_request(ACT_REMOVE, -2);
		send_request(ACT_SPARE, -1);

		// Random: alternate fill and drain phases, values mostly from a small pool.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			filling = ((n / PHASE_LEN) % 2) == 0;
			idling_on = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / PHASE_LEN) % 3 != 2);
			if (n == RANDOM_ITEMS / 2) wait_for_drain();
			if (n % 50 == 0) value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
			roll = $urandom_range(0, 99);
			if (roll < 3) act = ACT_SPARE;
			else if (roll < (filling ? 78 : 21)) act = ACT_PUSH;
			else if (roll < (filling ? 86 : 63)) act = ACT_POP;
			else act = ACT_REMOVE;
			if ($urandom_range(0, 3) != 0) val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			else val = $urandom();
			if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 5));
			send_request(act, val);
		end

		// Drain, then give the block time to show any stray result.
		wait_for_drain();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> fifo_queue_with_value_removal_top.f
sv/fqvr_pkg.sv
sv/fqvr_ram.sv
sv/fqvr_datapath.sv
sv/fqvr_ctrl.sv
sv/fifo_queue_with_value_removal_top.sv
sim/fqvr_result_checker.sv
sim/tb.sv
